// File: src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 morphology filter
// Register indexes, operator codes, item kinds and the structs that travel
// between the sequencer, the row store and the window kernel.
// ----------------------------------------------------------------------------
package mf3_pkg;

	localparam int PIXEL_W      = 8;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int MODE_REG_W   = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;

	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	typedef logic [PIXEL_W-1:0] pixel_t;

	localparam pixel_t PIXEL_MAX = 8'd255;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_OP_MODE
	} reg_index_t;

	typedef enum logic [MODE_REG_W-1:0] {
		MODE_BIN_ERODE,
		MODE_BIN_DILATE,
		MODE_GRAY_ERODE,
		MODE_GRAY_DILATE
	} mode_t;

	// which sides of the 3x3 neighborhood lie inside the frame
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} mask_t;

	typedef struct packed {
		logic  flush;
		logic  emit;
		logic  last;
		mask_t mask;
	} item_t;

	// one row store entry: the pixels two rows and one row above
	typedef struct packed {
		pixel_t above2;
		pixel_t above1;
	} entry_t;

endpackage

// File: src/mf3_row_mem.sv
// ----------------------------------------------------------------------------
// mf3_row_mem: line buffer memory
// Simple dual-port RAM holding the two previous rows per column; one write
// and one registered read per cycle, read-first on a same-address collision.
// ----------------------------------------------------------------------------
module mf3_row_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output mf3_pkg::entry_t      rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  mf3_pkg::entry_t      wr_data
);
	import mf3_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: src/mf3_seq.sv
// ----------------------------------------------------------------------------
// mf3_seq: configuration registers and raster position sequencer
// Tracks the input and output raster positions, decides what each accepted
// word does, and produces the line buffer address and border mask.
// ----------------------------------------------------------------------------
module mf3_seq #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int COL_W      = $clog2(MAX_WIDTH),
	parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mf3_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  logic                              kind,
	output logic                              act,
	output mf3_pkg::item_t                    item,
	output logic [COL_W-1:0]                  rd_addr,
	output mf3_pkg::mode_t                    op_mode,
	output logic                              restart
);
	import mf3_pkg::*;

	localparam logic [COL_W-1:0] WM1_RST =
		COL_W'((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1 : WIDTH_RST - 1);
	localparam logic [ROW_W-1:0] HM1_RST =
		ROW_W'((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT - 1 : HEIGHT_RST - 1);

	logic [COL_W-1:0] wm1_q, in_col_q, out_col_q, wm1_d;
	logic [ROW_W-1:0] hm1_q, in_row_q, out_row_q, hm1_d;
	logic             loaded_q;
	mode_t            mode_q;
	logic [31:0]      w_req, h_req;
	logic             wr_w, wr_h, wr_m;
	logic             is_flush, pix_act, fl_act, in_last, out_last, pix_emit, emit;

	// clamp width and height: zero acts as one, oversize as the maximum
	always_comb begin
		w_req = 32'(cfg_data[WIDTH_REG_W-1:0]);
		h_req = 32'(cfg_data[HEIGHT_REG_W-1:0]);
		if (w_req == 32'd0) begin
			wm1_d = '0;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			wm1_d = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1_d = COL_W'(w_req - 32'd1);
		end
		if (h_req == 32'd0) begin
			hm1_d = '0;
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			hm1_d = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1_d = ROW_W'(h_req - 32'd1);
		end
	end

	assign wr_w    = cfg_wr_en && (cfg_index == REG_IMAGE_WIDTH);
	assign wr_h    = cfg_wr_en && (cfg_index == REG_IMAGE_HEIGHT);
	assign wr_m    = cfg_wr_en && (cfg_index == REG_OP_MODE);
	assign restart = wr_w || wr_h;

	always_comb begin
		is_flush = (kind == KIND_FLUSH);
		pix_act  = !is_flush && !loaded_q;
		fl_act   = is_flush && loaded_q;
		act      = pix_act || fl_act;
		in_last  = (in_row_q == hm1_q) && (in_col_q == wm1_q);
		out_last = (out_row_q == hm1_q) && (out_col_q == wm1_q);
		// no result until the window center reaches the first pixel
		pix_emit = !((in_row_q == '0) || ((in_row_q == ROW_W'(1)) && (in_col_q == '0)));
		emit     = fl_act || (pix_act && pix_emit);

		item.flush      = is_flush;
		item.emit       = emit;
		item.last       = fl_act && out_last;
		item.mask.top   = (out_row_q != '0);
		item.mask.bot   = (out_row_q != hm1_q);
		item.mask.left  = (out_col_q != '0);
		item.mask.right = (out_col_q != wm1_q);

		// flush fetches the column right of the output position
		if (!is_flush) begin
			rd_addr = in_col_q;
		end else if (out_col_q == wm1_q) begin
			rd_addr = '0;
		end else begin
			rd_addr = out_col_q + COL_W'(1);
		end
	end

	assign op_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q     <= WM1_RST;
			hm1_q     <= HM1_RST;
			mode_q    <= MODE_BIN_ERODE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			loaded_q  <= 1'b0;
		end else begin
			if (wr_w) begin
				wm1_q <= wm1_d;
			end
			if (wr_h) begin
				hm1_q <= hm1_d;
			end
			if (wr_m) begin
				mode_q <= mode_t'(cfg_data[MODE_REG_W-1:0]);
			end
			if (restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				loaded_q  <= 1'b0;
			end else if (accept) begin
				if (pix_act) begin
					if (in_last) begin
						loaded_q <= 1'b1;
					end else if (in_col_q == wm1_q) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + ROW_W'(1);
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
				end
				if (fl_act && out_last) begin
					// frame done: start over for the next frame
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					loaded_q  <= 1'b0;
				end else if (emit) begin
					if (out_col_q == wm1_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

endmodule

// File: src/mf3_kernel.sv
// ----------------------------------------------------------------------------
// mf3_kernel: 3x3 window and morphology operator
// Holds the sliding window and evaluates binary or gray erosion/dilation on
// the window center, honoring the frame border mask.
// ----------------------------------------------------------------------------
module mf3_kernel (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  logic            shift_en,
	input  logic            shift_last,
	input  mf3_pkg::pixel_t col_top,
	input  mf3_pkg::pixel_t col_mid,
	input  mf3_pkg::pixel_t col_bot,
	input  mf3_pkg::mode_t  mode,
	input  mf3_pkg::mask_t  mask,
	output mf3_pkg::pixel_t result
);
	import mf3_pkg::*;

	pixel_t win_q [9];
	logic   clr_pend_q;
	pixel_t col_in [3];
	pixel_t vm [9];
	pixel_t l1 [4];
	pixel_t l2 [2];
	pixel_t l3, tree_out, center;
	logic   row_ok [3];
	logic   col_ok [3];
	logic   take_max, interior, any_zero, any_nonzero;

	function automatic pixel_t pick(input pixel_t a, input pixel_t b, input logic want_max);
		if (want_max) begin
			return (a > b) ? a : b;
		end
		return (a < b) ? a : b;
	endfunction

	assign col_in[0] = col_top;
	assign col_in[1] = col_mid;
	assign col_in[2] = col_bot;

	// after the last word of a frame, zero the old columns on the next shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			clr_pend_q <= 1'b0;
		end else if (restart) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			clr_pend_q <= 1'b0;
		end else if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= clr_pend_q ? '0 : win_q[r*3 + 1];
				win_q[r*3 + 1] <= clr_pend_q ? '0 : win_q[r*3 + 2];
				win_q[r*3 + 2] <= col_in[r];
			end
			clr_pend_q <= shift_last;
		end
	end

	always_comb begin
		row_ok[0] = mask.top;
		row_ok[1] = 1'b1;
		row_ok[2] = mask.bot;
		col_ok[0] = mask.left;
		col_ok[1] = 1'b1;
		col_ok[2] = mask.right;
		take_max  = (mode == MODE_GRAY_DILATE);
		center    = win_q[4];
		interior  = mask.top && mask.bot && mask.left && mask.right;

		// out-of-frame taps become neutral for min or max
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				vm[r*3 + c] = (row_ok[r] && col_ok[c]) ? win_q[r*3 + c] :
					(take_max ? '0 : PIXEL_MAX);
			end
		end

		any_zero    = 1'b0;
		any_nonzero = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				if (win_q[i] == '0) begin
					any_zero = 1'b1;
				end else begin
					any_nonzero = 1'b1;
				end
			end
		end

		for (int i = 0; i < 4; i++) begin
			l1[i] = pick(vm[2*i], vm[2*i + 1], take_max);
		end
		l2[0]    = pick(l1[0], l1[1], take_max);
		l2[1]    = pick(l1[2], l1[3], take_max);
		l3       = pick(l2[0], l2[1], take_max);
		tree_out = pick(l3, vm[8], take_max);

		case (mode)
			MODE_BIN_ERODE: begin
				result = (interior && (center != '0) && any_zero) ? '0 : center;
			end
			MODE_BIN_DILATE: begin
				result = (interior && (center == '0) && any_nonzero) ? PIXEL_MAX : center;
			end
			default: begin
				result = tree_out;
			end
		endcase
	end

endmodule

// File: src/morphology_filter_3x3.sv
// ----------------------------------------------------------------------------
// morphology_filter_3x3: streaming 3x3 erosion / dilation
// Raster-order 8-bit pixel stream in, filtered raster-order stream out, with
// two line buffers in one dual-port RAM and a 3x3 sliding window.
// ----------------------------------------------------------------------------
// Sustained rate is one word per clock while out_ready keeps the output free:
// each pixel word does one line buffer read and one write-back, a flush word a
// read only, which is what the single dual-port RAM allows. A result leaves W+1
// pixel words after its pixel (W = image_width). The word that releases it is
// registered into the read stage at its accepting edge, then into the window and
// the output register, which sets out_valid; out_ready can stall it on the way.
// After the last pixel of a frame, flush words drain the remaining results, W+1
// of them, or the whole frame when it holds fewer pixels; the last one carries
// frame_end. Writing image_width or image_height restarts the frame and must
// only happen while the filter is idle. No clearing pass runs after reset:
// border masking hides every line buffer entry not yet written.
// ----------------------------------------------------------------------------
module morphology_filter_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mf3_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [mf3_pkg::PIXEL_W-1:0]       pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mf3_pkg::PIXEL_W-1:0]       out_pixel,
	output logic                              frame_end
);
	import mf3_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic             accept, act, restart, ld_s1, wr_en, hit;
	logic             out_free, s2_go, s2_free, s1_go, s1_free;
	item_t            item_d;
	logic [COL_W-1:0] rd_addr;
	mode_t            mode;
	entry_t           rd_data, ent, wr_data;
	pixel_t           col_bot, result;

	logic             v_s1;
	item_t            item_s1;
	pixel_t           px_s1;
	logic [COL_W-1:0] addr_s1;
	logic             byp_s1;
	entry_t           bypd_s1;

	logic             v_s2;
	item_t            item_s2;

	logic             out_valid_q;
	pixel_t           out_pixel_q;
	logic             frame_end_q;

	// stage handshakes
	assign out_free = !out_valid_q || out_ready;
	assign s2_go    = v_s2 && (!item_s2.emit || out_free);
	assign s2_free  = !v_s2 || s2_go;
	assign s1_go    = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s1_go;
	assign in_ready = s1_free;
	assign accept   = in_valid && in_ready;
	assign ld_s1    = accept && act;

	mf3_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.kind      (kind),
		.act       (act),
		.item      (item_d),
		.rd_addr   (rd_addr),
		.op_mode   (mode),
		.restart   (restart)
	);

	// write back on the cycle the pixel word leaves stage 1
	assign wr_en   = s1_go && !item_s1.flush;
	assign ent     = byp_s1 ? bypd_s1 : rd_data;
	assign wr_data = '{above2: ent.above1, above1: px_s1};
	assign hit     = wr_en && (rd_addr == addr_s1);
	assign col_bot = item_s1.flush ? '0 : px_s1;

	mf3_row_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (ld_s1),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	mf3_kernel u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.shift_en   (s1_go),
		.shift_last (item_s1.last),
		.col_top    (ent.above2),
		.col_mid    (ent.above1),
		.col_bot    (col_bot),
		.mode       (mode),
		.mask       (item_s2.mask),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go && item_s2.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= item_d;
			px_s1   <= pixel;
			addr_s1 <= rd_addr;
			// same-entry write on this edge: forward it past the RAM
			byp_s1  <= hit;
			bypd_s1 <= wr_data;
		end
		if (s1_go) begin
			item_s2 <= item_s1;
		end
		if (s2_go && item_s2.emit) begin
			out_pixel_q <= result;
			frame_end_q <= item_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign frame_end = frame_end_q;

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && item_s2.emit && !out_free |=> v_s2 && item_s2.emit)
		else $error("pending result in window stage was lost");

	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s1 && hit |=> byp_s1)
		else $error("line buffer collision not forwarded");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && item_s1.last |-> item_s1.emit && item_s1.flush)
		else $error("frame end on a word that is not an emitting flush");

endmodule
